### src/cedf_pkg.sv
`timescale 1ns / 1ps

package cedf_pkg;

    localparam int PIX_W     = 32;
    localparam int IMG_W_W   = 12;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND_VALUE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND_MASK  = 2'd3;

    localparam logic             OP_ERODE      = 1'b0;
    localparam logic             OP_DILATE     = 1'b1;
    localparam logic [PIX_W-1:0] FG_MASK_RESET = 32'h0000_FFF0;
    localparam logic [PIX_W-1:0] BG_RESET      = 32'h0000_0000;

    typedef enum logic [2:0] {
        ST_FETCH0 = 3'b001,
        ST_FETCH1 = 3'b010,
        ST_RUN    = 3'b100
    } cedf_state_t;

    typedef struct packed {
        logic             frame_end;
        logic [PIX_W-1:0] pixel_out;
    } out_item_t;

endpackage

### src/cross_erode_dilate_filter_top.sv
`timescale 1ns / 1ps

// a result is written into the two-entry output FIFO when the request that completes its
// neighborhood is taken (the pixel below it, or a flush request for the last row)
// throughput: one request per cycle while s_tready is high, set by the single read
// port of each line memory; reset and every image_width write start a prefetch of
// the line memories (ST_FETCH0, ST_FETCH1) with s_tready low; the memories are never cleared
module cross_erode_dilate_filter_top #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [cedf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cedf_pkg::PIX_W-1:0]     cfg_data,
    // input stream
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [cedf_pkg::PIX_W-1:0]     s_tdata,   // [31:0] pixel_in
    input  logic [0:0]                s_tuser,   // [0] mode (flush tick)
    // result stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [cedf_pkg::PIX_W-1:0]     m_tdata,   // [31:0] pixel_out
    output logic                      m_tlast    // frame_end
);

    import cedf_pkg::*;

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    // line memories: row_a holds the previous row, row_b the row before it
    logic [PIX_W-1:0] row_a_mem [0:MAX_WIDTH-1];
    logic [PIX_W-1:0] row_b_mem [0:MAX_WIDTH-1];

    cedf_state_t state_reg, state_next;

    logic [AW-1:0]    last_reg, last_next;
    logic             op_reg, op_next;
    logic [PIX_W-1:0] bg_reg, bg_next;
    logic [PIX_W-1:0] mask_reg, mask_next;

    logic [AW-1:0]    cc_reg, cc_next;
    logic [1:0]       rows_reg, rows_next;
    logic             flushing_reg, flushing_next;

    logic [PIX_W-1:0] rd_a_reg, rd_b_reg;
    logic [PIX_W-1:0] cen_reg, cen_next;
    logic [PIX_W-1:0] left_reg, left_next;
    logic             rgt_fwd_reg, rgt_fwd_next;
    logic [PIX_W-1:0] rgt_hold_reg, rgt_hold_next;
    logic             abv_fwd_reg, abv_fwd_next;
    logic [PIX_W-1:0] abv_hold_reg, abv_hold_next;

    out_item_t        ofifo_reg [0:1];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       cnt_reg, cnt_next;

    logic [AW-1:0]    c_idx, nxt_idx, nxt2_idx;
    logic             last_col;
    logic [PIX_W-1:0] rgt_cur, abv_cur;
    logic             s_fire, m_fire, cfg_fire;
    logic             flush_tick, flush_skip, advance, pix_step, emit;
    logic             left_ok, right_ok, above_ok, below_ok;
    logic             rd_a_en, rd_b_en;
    logic [AW-1:0]    rd_a_addr, rd_b_addr;
    logic [PIX_W-1:0] below, res;
    logic             hit_bg;
    out_item_t        push_item;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign s_tready  = (state_reg == ST_RUN) && (cnt_reg != 2'd2);
    assign s_fire    = s_tvalid && s_tready;
    assign m_tvalid  = (cnt_reg != 2'd0);
    assign m_fire    = m_tvalid && m_tready;
    assign m_tdata   = ofifo_reg[rd_ptr_reg].pixel_out;
    assign m_tlast   = ofifo_reg[rd_ptr_reg].frame_end;

    // column walk with wrap into the next row
    always_comb begin
        c_idx    = (cc_reg > last_reg) ? last_reg : cc_reg;
        last_col = (c_idx == last_reg);
        nxt_idx  = last_col ? '0 : c_idx + AW'(1);
        nxt2_idx = (nxt_idx == last_reg) ? '0 : nxt_idx + AW'(1);
        rgt_cur  = rgt_fwd_reg ? rgt_hold_reg : rd_a_reg;
        abv_cur  = abv_fwd_reg ? abv_hold_reg : rd_b_reg;
    end

    // request classification
    always_comb begin
        flush_tick = flushing_reg || s_tuser[0];
        flush_skip = flush_tick && !flushing_reg && ((rows_reg == 2'd0) || (cc_reg != '0));
        advance    = s_fire && !flush_skip;
        pix_step   = advance && !flush_tick;
        emit       = advance && (flush_tick || (rows_reg != 2'd0));
    end

    // cross filter on the held row
    always_comb begin
        left_ok  = (c_idx != '0);
        right_ok = !last_col;
        above_ok = (rows_reg == 2'd2);
        below_ok = !flush_tick;
        below    = s_tdata;
        res      = cen_reg;
        hit_bg   = (left_ok && (left_reg == bg_reg)) || (above_ok && (abv_cur == bg_reg)) ||
                   (right_ok && (rgt_cur == bg_reg)) || (below_ok && (below == bg_reg));
        if (op_reg == OP_ERODE) begin
            if (((cen_reg & mask_reg) != '0) && hit_bg) begin
                res = bg_reg;
            end
        end else if (cen_reg == bg_reg) begin
            if (below_ok && ((below & mask_reg) != '0)) begin
                res = below;
            end else if (right_ok && ((rgt_cur & mask_reg) != '0)) begin
                res = rgt_cur;
            end else if (left_ok && ((left_reg & mask_reg) != '0)) begin
                res = left_reg;
            end else if (above_ok && ((abv_cur & mask_reg) != '0)) begin
                res = abv_cur;
            end
        end
        push_item.pixel_out = res;
        push_item.frame_end = flush_tick && last_col;
    end

    // memory read ports: prefetch above neighbor of next column and right neighbor two ahead
    always_comb begin
        rd_a_en   = 1'b0;
        rd_b_en   = 1'b0;
        rd_a_addr = nxt2_idx;
        rd_b_addr = nxt_idx;
        case (state_reg)
            ST_FETCH0: begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = c_idx;
                rd_b_addr = c_idx;
            end
            ST_FETCH1: begin
                rd_a_en   = 1'b1;
                rd_a_addr = nxt_idx;
            end
            ST_RUN: begin
                rd_a_en = advance;
                rd_b_en = advance;
            end
            default: begin
                rd_a_en = 1'b0;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next    = state_reg;
        last_next     = last_reg;
        op_next       = op_reg;
        bg_next       = bg_reg;
        mask_next     = mask_reg;
        cc_next       = cc_reg;
        rows_next     = rows_reg;
        flushing_next = flushing_reg;
        cen_next      = cen_reg;
        left_next     = left_reg;
        rgt_fwd_next  = rgt_fwd_reg;
        rgt_hold_next = rgt_hold_reg;
        abv_fwd_next  = abv_fwd_reg;
        abv_hold_next = abv_hold_reg;
        cnt_next      = cnt_reg + {1'b0, emit} - {1'b0, m_fire};

        case (state_reg)
            ST_FETCH0: begin
                state_next = ST_FETCH1;
            end
            ST_FETCH1: begin
                state_next   = ST_RUN;
                cen_next     = rd_a_reg;
                rgt_fwd_next = 1'b0;
                abv_fwd_next = 1'b0;
            end
            ST_RUN: begin
                if (advance) begin
                    left_next     = (flush_tick || (rows_reg != 2'd0)) ? cen_reg : s_tdata;
                    cen_next      = (pix_step && (nxt_idx == c_idx)) ? s_tdata : rgt_cur;
                    rgt_fwd_next  = pix_step && (nxt2_idx == c_idx);
                    rgt_hold_next = s_tdata;
                    abv_fwd_next  = pix_step && (nxt_idx == c_idx);
                    abv_hold_next = cen_reg;
                    cc_next       = last_col ? '0 : c_idx + AW'(1);
                    if (flush_tick) begin
                        flushing_next = !last_col;
                        if (last_col) begin
                            rows_next = 2'd0;
                        end
                    end else if (last_col && (rows_reg != 2'd2)) begin
                        rows_next = rows_reg + 2'd1;
                    end
                end
            end
            default: begin
                state_next = ST_FETCH0;
            end
        endcase

        if (cfg_fire) begin
            case (cfg_index)
                CFG_IMAGE_WIDTH: begin
                    if (cfg_data[IMG_W_W-1:0] == '0) begin
                        last_next = '0;
                    end else if (int'(cfg_data[IMG_W_W-1:0]) > MAX_WIDTH) begin
                        last_next = AW'(MAX_WIDTH - 1);
                    end else begin
                        last_next = AW'(cfg_data[IMG_W_W-1:0] - 12'd1);
                    end
                    // prefetch again for the clamped column
                    state_next = ST_FETCH0;
                end
                CFG_OPERATION:        op_next   = cfg_data[0];
                CFG_BACKGROUND_VALUE: bg_next   = cfg_data;
                CFG_FOREGROUND_MASK:  mask_next = cfg_data;
                default:              op_next   = op_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FETCH0;
            last_reg     <= '0;
            op_reg       <= OP_ERODE;
            bg_reg       <= BG_RESET;
            mask_reg     <= FG_MASK_RESET;
            cc_reg       <= '0;
            rows_reg     <= 2'd0;
            flushing_reg <= 1'b0;
            rgt_fwd_reg  <= 1'b0;
            abv_fwd_reg  <= 1'b0;
            wr_ptr_reg   <= 1'b0;
            rd_ptr_reg   <= 1'b0;
            cnt_reg      <= 2'd0;
        end else begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            op_reg       <= op_next;
            bg_reg       <= bg_next;
            mask_reg     <= mask_next;
            cc_reg       <= cc_next;
            rows_reg     <= rows_next;
            flushing_reg <= flushing_next;
            rgt_fwd_reg  <= rgt_fwd_next;
            abv_fwd_reg  <= abv_fwd_next;
            wr_ptr_reg   <= wr_ptr_reg ^ emit;
            rd_ptr_reg   <= rd_ptr_reg ^ m_fire;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cen_reg      <= cen_next;
        left_reg     <= left_next;
        rgt_hold_reg <= rgt_hold_next;
        abv_hold_reg <= abv_hold_next;
        if (emit) begin
            ofifo_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_step) begin
            row_a_mem[c_idx] <= s_tdata;
        end
        if (rd_a_en) begin
            rd_a_reg <= row_a_mem[rd_a_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (pix_step) begin
            row_b_mem[c_idx] <= cen_reg;
        end
        if (rd_b_en) begin
            rd_b_reg <= row_b_mem[rd_b_addr];
        end
    end

endmodule
